[rtl/hbit_pkg.sv]
// hbit_pkg: shared widths, codes, state types and arithmetic helpers for the
// bucketed hash table. Depends on nothing; every other file imports it.
package hbit_pkg;

  localparam int DEF_BUCKETS = 10;
  localparam int DEF_SLOTS   = 8;

  // field widths of the channels
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int BKT_W    = 4;
  localparam int SEL_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 4;
  localparam int MODE_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DIV  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MID  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOLD = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // square of a 16-bit key, and the operand of the final mod
  localparam int SQ_W  = 32;
  // mid-square keeps at most six decimal digits, so below 2^20
  localparam int MOD_W = 20;
  localparam int FOLD_DIGITS = 5;

  localparam int POW10_N = 10;
  localparam logic [SQ_W-1:0] POW10 [POW10_N] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  // ceil(2^36 / 10) gives an exact quotient for any 32-bit value
  localparam logic [32:0] DIV10_MUL   = 33'h1_9999_999A;
  localparam int          DIV10_SHIFT = 36;

  function automatic logic [SQ_W-1:0] div10(input logic [SQ_W-1:0] x);
    logic [64:0] p;
    p = {33'd0, x} * {32'd0, DIV10_MUL};
    return SQ_W'(p[64:DIV10_SHIFT]);
  endfunction

  typedef enum logic [1:0] {
    T_IDLE,
    T_HASH,
    T_LOOK,
    T_FIN
  } top_state_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_SQ,
    H_DCNT,
    H_DIV,
    H_FOLD,
    H_MODQ,
    H_MODR
  } hash_state_t;

  typedef struct packed {
    logic              start;
    logic [MODE_W-1:0] mode;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } hash_rsp_t;

endpackage

[rtl/hbit_hash.sv]
// hbit_hash: multi-cycle key hash (division, mid-square, digit folding).
// Depends on hbit_pkg for the divide-by-ten helper, codes and types.
module hbit_hash
  import hbit_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hash_req_t        req,
  input  logic [KEY_W-1:0] key,
  output hash_rsp_t        rsp
);

  // reciprocal for x mod BUCKETS, exact for x < 2^MOD_W
  localparam int MOD_L  = $clog2(BUCKETS);
  localparam int MOD_S  = MOD_W + MOD_L;
  localparam int MOD_MW = MOD_W + 2;
  localparam logic [MOD_MW-1:0] MOD_M =
    MOD_MW'(((64'd1 << MOD_S) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  localparam int SHIFT_MAX = (POW10_N + 1) / 2 - 1;
  localparam int SHF_W     = $clog2(SHIFT_MAX + 1);
  localparam int DCNT_W    = $clog2(POW10_N + 1);
  localparam int STEP_W    = $clog2(FOLD_DIGITS + 1);
  localparam int SUM_W     = 8;

  hash_state_t state_r, state_nxt;
  logic [SQ_W-1:0]  num_r, num_nxt;
  logic [SQ_W-1:0]  lo_r, lo_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SHF_W-1:0] shf_r, shf_nxt;
  logic [MOD_W-1:0] modv_r, modv_nxt;
  logic [MOD_W-1:0] modq_r, modq_nxt;

  logic [SQ_W-1:0]    quo;
  logic [SQ_W-1:0]    sq;
  logic [7:0]         dig8;
  logic [3:0]         dig;
  logic [SUM_W-1:0]   wdig;
  logic [SUM_W-1:0]   sum_add;
  logic [POW10_N-1:0] ge;
  logic [DCNT_W-1:0]  ndig;
  logic [DCNT_W-1:0]  mid;
  logic [SHF_W-1:0]   shf_set;
  logic [MOD_W+MOD_MW-1:0] mprod;
  logic [MOD_W-1:0]   rem;

  assign quo = div10(num_r);
  assign sq  = {16'd0, num_r[KEY_W-1:0]} * {16'd0, num_r[KEY_W-1:0]};

  // folding: lo_r holds the previous value and num_r its quotient
  assign dig8    = lo_r[7:0] - 8'(num_r[7:0] * 8'd10);
  assign dig     = dig8[3:0];
  assign wdig    = step_r[0] ? {4'd0, dig} : 8'({4'd0, dig} * 8'd10);
  assign sum_add = sum_r + wdig;

  always_comb begin
    for (int i = 0; i < POW10_N; i++) begin
      ge[i] = (num_r >= POW10[i]);
    end
  end

  assign ndig    = DCNT_W'($countones(ge));
  assign mid     = DCNT_W'((ndig + 1'b1) >> 1);
  assign shf_set = (mid == '0) ? '0 : SHF_W'(mid - 1'b1);

  assign mprod = {{MOD_MW{1'b0}}, modv_r} * {{MOD_W{1'b0}}, MOD_M};
  assign rem   = modv_r - MOD_W'(modq_r * MOD_W'(BUCKETS));

  assign rsp.done   = (state_r == H_MODR);
  assign rsp.bucket = BKT_W'(rem);

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    lo_nxt    = lo_r;
    sum_nxt   = sum_r;
    step_nxt  = step_r;
    shf_nxt   = shf_r;
    modv_nxt  = modv_r;
    modq_nxt  = modq_r;
    unique case (state_r)
      H_IDLE: begin
        if (req.start) begin
          unique case (req.mode)
            MODE_MID: begin
              num_nxt   = {16'd0, key};
              state_nxt = H_SQ;
            end
            MODE_FOLD: begin
              num_nxt   = {16'd0, key};
              step_nxt  = '0;
              sum_nxt   = '0;
              state_nxt = H_FOLD;
            end
            default: begin
              modv_nxt  = MOD_W'(key);
              state_nxt = H_MODQ;
            end
          endcase
        end
      end
      H_SQ: begin
        num_nxt   = sq;
        state_nxt = H_DCNT;
      end
      H_DCNT: begin
        shf_nxt   = shf_set;
        state_nxt = H_DIV;
      end
      H_DIV: begin
        if (shf_r == '0) begin
          modv_nxt  = num_r[MOD_W-1:0];
          state_nxt = H_MODQ;
        end else begin
          num_nxt = quo;
          shf_nxt = shf_r - 1'b1;
        end
      end
      H_FOLD: begin
        num_nxt  = quo;
        lo_nxt   = num_r;
        step_nxt = step_r + 1'b1;
        if (step_r != '0) begin
          sum_nxt = sum_add;
        end
        if (step_r == STEP_W'(FOLD_DIGITS)) begin
          modv_nxt  = MOD_W'(sum_add);
          state_nxt = H_MODQ;
        end
      end
      H_MODQ: begin
        modq_nxt  = MOD_W'(mprod >> MOD_S);
        state_nxt = H_MODR;
      end
      H_MODR: begin
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    lo_r   <= lo_nxt;
    sum_r  <= sum_nxt;
    step_r <= step_nxt;
    shf_r  <= shf_nxt;
    modv_r <= modv_nxt;
    modq_r <= modq_nxt;
  end

endmodule

[rtl/hash_bucket_insert_table_top.sv]
// hash_bucket_insert_table_top: bucketed hash table with bounded chains.
// Depends on hbit_pkg and instantiates hbit_hash.
//
// Input channel (in_valid/in_ready) carries one operation: insert a key,
// read the entry at a bucket and slot, or clear all buckets. Function code
// 3 is taken and dropped with no result. Each other operation gives one
// result on the out_valid/out_ready channel, held in an output register.
// cfg_wr_en writes the hash method; write it only while the block is idle.
//
// One operation at a time. A clear goes straight to the result step. A read
// first takes the lookup step, a registered read of the count and entry
// memories before the write-back. An insert first runs the hash sequencer
// (one divide-by-ten step a cycle, one step per decimal digit dropped from
// a mid-square, then a reciprocal mod as a quotient and a remainder step)
// and then the lookup step.
// If the receiver stalls, the finished result waits in the last step and
// no memory is updated until it can be loaded into the output register.
// Reset clears the per-bucket valid bits (all counts read as zero), the
// hash method and the output valid flag; there is no clearing pass.
module hash_bucket_insert_table_top
  import hbit_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int SLOTS   = DEF_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [MODE_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [BKT_W-1:0]    in_bucket_sel,
  input  logic [SEL_W-1:0]    in_slot_sel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [BKT_W-1:0]    out_bucket,
  output logic [SEL_W-1:0]    out_slot,
  output logic [KEY_W-1:0]    out_value,
  output logic [FILL_W-1:0]   out_fill
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int DEPTH = BUCKETS * SLOTS;
  localparam int AW    = $clog2(DEPTH);

  top_state_t state_r, state_nxt;

  logic [MODE_W-1:0] hash_mode_r;
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [BKT_W-1:0]  bsel_r;
  logic [SEL_W-1:0]  ssel_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [BUCKETS-1:0] cnt_vld_r;
  logic [CW-1:0]     cnt_rd_r;
  logic [KEY_W-1:0]  ent_rd_r;

  logic [CW-1:0]    cnt_mem [BUCKETS];
  logic [KEY_W-1:0] ent_mem [DEPTH];

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BKT_W-1:0]    out_bucket_r, out_bucket_nxt;
  logic [SEL_W-1:0]    out_slot_r, out_slot_nxt;
  logic [KEY_W-1:0]    out_value_r, out_value_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  logic          in_xfer;
  logic          commit;
  logic          bsel_ok;
  logic          ssel_ok;
  logic [BW-1:0] cidx;
  logic [CW-1:0] n;
  logic [CW-1:0] n_inc;
  logic          full;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          cnt_we;

  assign in_ready = (state_r == T_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign commit   = (state_r == T_FIN) && (!out_valid_r || out_ready);

  assign hreq.start = in_xfer && (in_func == FUNC_INSERT);
  assign hreq.mode  = hash_mode_r;

  hbit_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .key   (in_key),
    .rsp   (hrsp)
  );

  assign bsel_ok = (int'(bsel_r) < BUCKETS);
  assign ssel_ok = bsel_ok && (int'(ssel_r) < SLOTS);
  assign cidx    = (func_r == FUNC_INSERT) ? bkt_r[BW-1:0] :
                   (bsel_ok ? bsel_r[BW-1:0] : '0);

  // a bucket without its valid bit has been emptied since last written
  assign n      = cnt_vld_r[cidx] ? cnt_rd_r : '0;
  assign n_inc  = n + 1'b1;
  assign full   = (int'(n) >= SLOTS);
  assign raddr  = ssel_ok ? AW'(int'(bsel_r) * SLOTS + int'(ssel_r)) : '0;
  assign waddr  = AW'(int'(bkt_r) * SLOTS + int'(n));
  assign cnt_we = commit && (func_r == FUNC_INSERT) && !full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            FUNC_INSERT: state_nxt = T_HASH;
            FUNC_READ:   state_nxt = T_LOOK;
            FUNC_CLEAR:  state_nxt = T_FIN;
            default:     state_nxt = T_IDLE;
          endcase
        end
      end
      T_HASH: begin
        if (hrsp.done) begin
          state_nxt = T_LOOK;
        end
      end
      T_LOOK: begin
        state_nxt = T_FIN;
      end
      T_FIN: begin
        if (commit) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_status_nxt = STAT_OK;
    out_bucket_nxt = '0;
    out_slot_nxt   = '0;
    out_value_nxt  = '0;
    out_fill_nxt   = '0;
    case (func_r)
      FUNC_INSERT: begin
        out_bucket_nxt = bkt_r;
        out_value_nxt  = key_r;
        if (full) begin
          out_status_nxt = STAT_FULL;
          out_fill_nxt   = FILL_W'(SLOTS);
        end else begin
          out_slot_nxt = SEL_W'(n);
          out_fill_nxt = FILL_W'(n_inc);
        end
      end
      FUNC_READ: begin
        out_bucket_nxt = bsel_r;
        out_slot_nxt   = ssel_r;
        if (!bsel_ok) begin
          out_status_nxt = STAT_EMPTY;
        end else if (!ssel_ok || (int'(ssel_r) >= int'(n))) begin
          out_status_nxt = STAT_EMPTY;
          out_fill_nxt   = FILL_W'(n);
        end else begin
          out_value_nxt = ent_rd_r;
          out_fill_nxt  = FILL_W'(n);
        end
      end
      default: begin
        // clear gives an all-zero result
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      hash_mode_r <= MODE_DIV;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        hash_mode_r <= cfg_wr_data;
      end
      if (commit && (func_r == FUNC_CLEAR)) begin
        cnt_vld_r <= '0;
      end else if (cnt_we) begin
        cnt_vld_r[cidx] <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_func;
      key_r  <= in_key;
      bsel_r <= in_bucket_sel;
      ssel_r <= in_slot_sel;
    end
    if ((state_r == T_HASH) && hrsp.done) begin
      bkt_r <= hrsp.bucket;
    end
    if (commit) begin
      out_status_r <= out_status_nxt;
      out_bucket_r <= out_bucket_nxt;
      out_slot_r   <= out_slot_nxt;
      out_value_r  <= out_value_nxt;
      out_fill_r   <= out_fill_nxt;
    end
  end

  // bucket count memory: read in the lookup step, written back when an insert into a bucket that is not full commits
  always_ff @(posedge clk) begin
    if (state_r == T_LOOK) begin
      cnt_rd_r <= cnt_mem[cidx];
    end
    if (cnt_we) begin
      cnt_mem[cidx] <= n_inc;
    end
  end

  // entry memory: one row of SLOTS entries per bucket
  always_ff @(posedge clk) begin
    if (state_r == T_LOOK) begin
      ent_rd_r <= ent_mem[raddr];
    end
    if (cnt_we) begin
      ent_mem[waddr] <= key_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bucket = out_bucket_r;
  assign out_slot   = out_slot_r;
  assign out_value  = out_value_r;
  assign out_fill   = out_fill_r;

endmodule

[rtl/hbit_checker.sv]
// hbit_checker: port-level assertions for the hash table top level, and
// the bind that attaches them. Depends on hbit_pkg for codes.
module hbit_checker
  import hbit_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [FUNC_W-1:0]   in_func,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [BKT_W-1:0]    out_bucket,
  input logic [SEL_W-1:0]    out_slot,
  input logic [KEY_W-1:0]    out_value,
  input logic [FILL_W-1:0]   out_fill
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_bucket) && $stable(out_slot) && $stable(out_value) &&
      $stable(out_fill))
    else $error("result changed while stalled");

  // taking any real operation (insert, read or clear) makes the block busy and drops in_ready
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_INSERT || in_func == FUNC_READ ||
      in_func == FUNC_CLEAR) |=> !in_ready)
    else $error("new transfer taken while an operation is in flight");

  // clear with a free output register commits from the result step; OK status, zero fill and value
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_CLEAR) && !out_valid |=>
      ##1 out_valid && (out_status == STAT_OK) && (out_fill == '0) &&
      (out_value == '0))
    else $error("clear result missing or wrong");

  // reset leaves nothing pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind hash_bucket_insert_table_top hbit_checker u_chk (.*);
